### src/first_fit_heap_allocator_defines.svh
// Assertion macros shared by the checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Asserts that a condition implies a consequence in the next cycle.
`define FFHA_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

// Asserts that a condition implies a consequence in the same cycle.
`define FFHA_SAME(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

`endif

### src/ffha_pkg.sv
package ffha_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOSPACE = 3'd1;
  localparam logic [2:0] ST_DOUBLE  = 3'd2;
  localparam logic [2:0] ST_NULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  localparam logic [31:0] HEAP_LIMIT_RESET = 32'd1048576;
  localparam logic [31:0] ALIGN_MASK = 32'd7;

  typedef struct packed {
    logic [31:0] size;
    logic        is_free;
  } blk_entry_t;

endpackage

### src/ffha_table.sv
module ffha_table #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_BLOCKS)-1:0] wr_idx,
  input  ffha_pkg::blk_entry_t          wr_data,
  input  logic [$clog2(MAX_BLOCKS)-1:0] rd_idx,
  output ffha_pkg::blk_entry_t          rd_data
);
  import ffha_pkg::*;

  blk_entry_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data <= mem[rd_idx];
  end

endmodule

### src/first_fit_heap_allocator.sv
// First-fit heap allocator. Each request is an allocate or a free and yields
// one result with a payload address and a status. The block table lives in a
// single-port-read memory that a small sequencer walks one entry at a time
// (read issue, then evaluate); when a split inserts or a merge removes an
// entry, each entry shifted takes its own read and write step. One adder with
// 33-bit operands is shared by the walk, append and merge steps. The block
// accepts no request while one is in progress; a finished result waits in the
// output register and the next request is taken once it has been delivered.
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS      = 256,
  parameter int HEADER_BYTES    = 16,
  parameter int MIN_SPLIT_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [31:0] req_size,
  input  logic [31:0] addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] addr_out,
  output logic [2:0]  status
);
  import ffha_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
  localparam logic [32:0] HDR = 33'(HEADER_BYTES);
  localparam logic [32:0] HDR_SPLIT = 33'(HEADER_BYTES + MIN_SPLIT_BYTES);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_EVAL   = 4'd2;
  localparam logic [3:0] S_APPEND = 4'd3;
  localparam logic [3:0] S_INS_RD = 4'd4;
  localparam logic [3:0] S_INS_WR = 4'd5;
  localparam logic [3:0] S_NEXT_RD= 4'd6;
  localparam logic [3:0] S_NEXT_EV= 4'd7;
  localparam logic [3:0] S_REM_RD = 4'd8;
  localparam logic [3:0] S_REM_WR = 4'd9;
  localparam logic [3:0] S_PREV_RD= 4'd10;
  localparam logic [3:0] S_PREV_EV= 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0]    state;
  logic [31:0]   heap_base;
  logic [31:0]   heap_limit;
  logic [CW-1:0] block_count;
  logic [31:0]   heap_end_offset;
  logic          op;
  logic [32:0]   want;
  logic [31:0]   target;
  logic [CW-1:0] k;
  logic [CW-1:0] j;
  logic [32:0]   off;
  logic [31:0]   cur_size;
  logic          cur_free;
  logic [31:0]   ins_size;
  logic          rm_pending;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  blk_entry_t    wr_data;
  logic [IW-1:0] rd_idx;
  blk_entry_t    rd_data;

  logic [32:0]   sum_a;
  logic [32:0]   sum_b;
  logic [33:0]   sum;
  logic [32:0]   rounded;

  ffha_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_data(wr_data),
    .rd_idx (rd_idx),
    .rd_data(rd_data)
  );

  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign rounded   = ({1'b0, req_size} + 33'd7) & ~33'(ALIGN_MASK);
  assign sum       = {1'b0, sum_a} + {1'b0, sum_b};

  // Shared adder operand selection.
  always_comb begin
    sum_a = 33'd0;
    sum_b = 33'd0;
    unique case (state)
      S_EVAL: begin
        sum_a = off;
        sum_b = HDR + {1'b0, rd_data.size};
      end
      S_APPEND: begin
        sum_a = {1'b0, heap_base} + {1'b0, heap_end_offset};
        sum_b = HDR + want;
      end
      S_NEXT_EV, S_PREV_EV: begin
        sum_a = {1'b0, cur_size};
        sum_b = HDR + {1'b0, rd_data.size};
      end
      default: begin
        sum_a = 33'd0;
        sum_b = 33'd0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = k[IW-1:0];
    wr_data = '{size: cur_size, is_free: cur_free};
    rd_idx  = k[IW-1:0];
    unique case (state)
      S_RD:      rd_idx = k[IW-1:0];
      S_INS_RD:  rd_idx = IW'(j - CW'(1));
      S_NEXT_RD: rd_idx = IW'(k + CW'(1));
      S_REM_RD:  rd_idx = IW'(j + CW'(1));
      S_PREV_RD: rd_idx = IW'(k - CW'(1));
      default:   rd_idx = k[IW-1:0];
    endcase
    unique case (state)
      S_INS_WR: begin
        wr_en  = 1'b1;
        wr_idx = j[IW-1:0];
        if (j == k + CW'(1)) begin
          wr_data = '{size: ins_size, is_free: 1'b1};
        end else begin
          wr_data = rd_data;
        end
      end
      S_REM_WR: begin
        wr_en   = 1'b1;
        wr_idx  = j[IW-1:0];
        wr_data = rd_data;
      end
      S_DONE: begin
        wr_en  = 1'b1;
        wr_idx = k[IW-1:0];
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      heap_base       <= '0;
      heap_limit      <= HEAP_LIMIT_RESET;
      block_count     <= '0;
      heap_end_offset <= '0;
      out_valid       <= 1'b0;
      rm_pending      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_HEAP_BASE) begin
              heap_base <= cfg_data;
            end else begin
              heap_limit <= cfg_data;
            end
          end
          if (in_valid && !in_stall) begin
            op         <= cmd;
            target     <= addr;
            want       <= rounded;
            k          <= '0;
            off        <= {1'b0, heap_base} + HDR;
            rm_pending <= 1'b0;
            addr_out   <= '0;
            if (cmd == CMD_FREE && addr == 32'd0) begin
              status    <= ST_NULL;
              out_valid <= 1'b1;
            end else if (cmd == CMD_ALLOC && rounded[32]) begin
              status    <= ST_NOSPACE;
              out_valid <= 1'b1;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          if (k == block_count) begin
            if (op == CMD_ALLOC) begin
              state <= S_APPEND;
            end else begin
              status    <= ST_UNKNOWN;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          cur_size <= rd_data.size;
          cur_free <= rd_data.is_free;
          if (op == CMD_ALLOC) begin
            if (rd_data.is_free && {1'b0, rd_data.size} >= want) begin
              addr_out <= off[31:0];
              status   <= ST_OK;
              cur_free <= 1'b0;
              if ({1'b0, rd_data.size} >= want + HDR_SPLIT && block_count < CNT_MAX) begin
                ins_size <= 32'({1'b0, rd_data.size} - want - HDR);
                cur_size <= want[31:0];
                j        <= block_count;
                state    <= S_INS_RD;
              end else begin
                state <= S_DONE;
              end
            end else begin
              off   <= sum[32:0];
              k     <= k + CW'(1);
              state <= S_RD;
            end
          end else begin
            if (off[31:0] == target) begin
              if (rd_data.is_free) begin
                status    <= ST_DOUBLE;
                out_valid <= 1'b1;
                state     <= S_IDLE;
              end else begin
                status   <= ST_OK;
                cur_free <= 1'b1;
                state    <= S_NEXT_RD;
              end
            end else begin
              off   <= sum[32:0];
              k     <= k + CW'(1);
              state <= S_RD;
            end
          end
        end
        S_APPEND: begin
          if (block_count >= CNT_MAX || sum >= {2'b00, heap_limit}) begin
            status    <= ST_NOSPACE;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            addr_out        <= 32'({1'b0, heap_base} + {1'b0, heap_end_offset} + HDR);
            status          <= ST_OK;
            heap_end_offset <= 32'({1'b0, heap_end_offset} + HDR + want);
            cur_size        <= want[31:0];
            cur_free        <= 1'b0;
            block_count     <= block_count + CW'(1);
            state           <= S_DONE;
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          if (j == k + CW'(1)) begin
            block_count <= block_count + CW'(1);
            state       <= S_DONE;
          end else begin
            j     <= j - CW'(1);
            state <= S_INS_RD;
          end
        end
        S_NEXT_RD: begin
          if (k + CW'(1) < block_count) begin
            state <= S_NEXT_EV;
          end else begin
            state <= S_PREV_RD;
          end
        end
        S_NEXT_EV: begin
          if (rd_data.is_free) begin
            cur_size   <= sum[31:0];
            j          <= k + CW'(1);
            rm_pending <= 1'b0;
            state      <= S_REM_RD;
          end else begin
            state <= S_PREV_RD;
          end
        end
        S_REM_RD: begin
          if (j + CW'(1) < block_count) begin
            state <= S_REM_WR;
          end else begin
            block_count <= block_count - CW'(1);
            if (rm_pending) begin
              state <= S_DONE;
            end else begin
              state <= S_PREV_RD;
            end
          end
        end
        S_REM_WR: begin
          j     <= j + CW'(1);
          state <= S_REM_RD;
        end
        S_PREV_RD: begin
          if (k != '0) begin
            state <= S_PREV_EV;
          end else begin
            state <= S_DONE;
          end
        end
        S_PREV_EV: begin
          if (rd_data.is_free) begin
            // Close the gap at the old index k first; the merged block is written at k-1 in S_DONE.
            cur_size   <= sum[31:0];
            k          <= k - CW'(1);
            j          <= k;
            rm_pending <= 1'b1;
            state      <= S_REM_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/ffha_checker.sv
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_ready,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] addr_out,
  input logic [2:0]  status
);
  import ffha_pkg::*;

  `FFHA_SAME(a_fail_addr_zero, out_valid && status != ST_OK, addr_out == 32'd0,
    "failed request reports a nonzero address")
  `FFHA_SAME(a_status_range, out_valid, status <= ST_UNKNOWN, "status code out of range")
  `FFHA_NEXT(a_one_result, in_valid && !in_stall, !out_valid || !$past(out_valid),
    "request accepted while a result was pending")
  `FFHA_SAME(a_cfg_idle, cfg_ready, !in_stall, "configuration taken while busy")
  `FFHA_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status),
    "stalled result changed")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk      (clk),
  .rst      (rst),
  .cfg_ready(cfg_ready),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .addr_out (addr_out),
  .status   (status)
);

### tb/first_fit_heap_allocator_tb.sv
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int NBLK = 256;
  localparam int HDR = 16;
  localparam int MINSPLIT = 8;
  localparam int CYCLE_LIMIT = 6000000;

  typedef struct {
    logic        cmd;
    logic [31:0] size;
    logic [31:0] addr;
    bit          typed;
    logic [31:0] exp_addr;
    logic [2:0]  exp_status;
  } row_t;

  typedef struct {
    logic [31:0] addr;
    logic [2:0]  status;
  } outcome_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, cmd;
  logic [31:0] req_size, addr;
  logic out_valid, out_stall;
  logic [31:0] addr_out;
  logic [2:0] status;

  first_fit_heap_allocator i_dut (.*);

  logic [31:0] blk_size [NBLK];
  bit          blk_free [NBLK];
  int          blk_count;
  logic [31:0] end_offset;
  logic [31:0] base_reg, limit_reg;

  outcome_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int rx_hold = 0;
  bit rx_quiet = 0;
  bit tx_quiet = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void table_insert(int k, logic [31:0] sz, bit fr);
    for (int i = blk_count; i > k; i--) begin
      blk_size[i] = blk_size[i-1];
      blk_free[i] = blk_free[i-1];
    end
    blk_size[k] = sz;
    blk_free[k] = fr;
    blk_count++;
  endfunction

  function automatic void table_remove(int k);
    for (int i = k; i + 1 < blk_count; i++) begin
      blk_size[i] = blk_size[i+1];
      blk_free[i] = blk_free[i+1];
    end
    blk_count--;
  endfunction

  function automatic outcome_t heap_alloc(logic [31:0] req);
    logic [63:0] want, off, sz, hdr;
    outcome_t r;
    want = ({32'd0, req} + 64'd7) & ~64'd7;
    off = 0;
    r.addr = 0;
    r.status = ST_NOSPACE;
    if (want > 64'hFFFF_FFFF) return r;
    for (int k = 0; k < blk_count; k++) begin
      sz = {32'd0, blk_size[k]};
      if (blk_free[k] && sz >= want) begin
        if (sz >= want + HDR + MINSPLIT && blk_count < NBLK) begin
          table_insert(k + 1, 32'(sz - want - HDR), 1);
          blk_size[k] = 32'(want);
        end
        blk_free[k] = 0;
        r.status = ST_OK;
        r.addr = 32'({32'd0, base_reg} + off + HDR);
        return r;
      end
      off += HDR + sz;
    end
    hdr = {32'd0, base_reg} + {32'd0, end_offset};
    if (blk_count >= NBLK || hdr + HDR + want >= {32'd0, limit_reg}) return r;
    table_insert(blk_count, 32'(want), 0);
    end_offset = 32'({32'd0, end_offset} + HDR + want);
    r.status = ST_OK;
    r.addr = 32'(hdr + HDR);
    return r;
  endfunction

  function automatic logic [2:0] heap_free(logic [31:0] a);
    logic [63:0] off;
    int k;
    if (a == 0) return ST_NULL;
    off = 0;
    for (k = 0; k < blk_count; k++) begin
      if (32'({32'd0, base_reg} + off + HDR) == a) break;
      off += HDR + {32'd0, blk_size[k]};
    end
    if (k >= blk_count) return ST_UNKNOWN;
    if (blk_free[k]) return ST_DOUBLE;
    blk_free[k] = 1;
    if (k + 1 < blk_count && blk_free[k+1]) begin
      blk_size[k] = blk_size[k] + HDR + blk_size[k+1];
      table_remove(k + 1);
    end
    if (k > 0 && blk_free[k-1]) begin
      blk_size[k-1] = blk_size[k-1] + HDR + blk_size[k];
      table_remove(k);
    end
    return ST_OK;
  endfunction

  function automatic logic [31:0] payload_addr(int k);
    logic [63:0] off;
    off = 0;
    for (int i = 0; i < k; i++) off += HDR + {32'd0, blk_size[i]};
    return 32'({32'd0, base_reg} + off + HDR);
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result addr_out=%h status=%0d", addr_out, status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (addr_out !== e.addr) begin
          $error("addr_out expected %h actual %h", e.addr, addr_out);
          errors++;
        end
        if (status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, status);
          errors++;
        end
      end
      if (rx_hold == 0) rx_hold = rx_quiet ? 0 : $urandom_range(0, 19);
    end
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1;
      rx_hold--;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send(row_t r);
    int gap;
    outcome_t e;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    cmd <= r.cmd;
    req_size <= r.size;
    addr <= r.addr;
    do @(posedge clk); while (in_stall);
    if (r.cmd == CMD_ALLOC) begin
      e = heap_alloc(r.size);
    end else begin
      e.addr = 0;
      e.status = heap_free(r.addr);
    end
    if (r.typed) begin
      e.addr = r.exp_addr;
      e.status = r.exp_status;
    end
    pending_results.push_back(e);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    in_valid <= 0;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_HEAP_BASE) base_reg = val;
    else limit_reg = val;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic random_requests(int n, int big_pct);
    row_t r;
    int roll;
    for (int i = 0; i < n; i++) begin
      r.typed = 0;
      r.addr = $urandom;
      r.size = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        r.cmd = CMD_ALLOC;
        if ($urandom_range(0, 99) >= big_pct) r.size = $urandom_range(0, 200);
      end else begin
        r.cmd = CMD_FREE;
        if (roll < 90 && blk_count > 0) r.addr = payload_addr($urandom_range(0, blk_count - 1));
        else if (roll < 93) r.addr = 0;
      end
      if ($urandom_range(0, 3) == 0) r.cmd = ~r.cmd;
      send(r);
    end
  endtask

  row_t directed[$];

  initial begin
    rst = 1;
    cfg_valid = 0;
    cfg_index = CFG_HEAP_BASE;
    cfg_data = 0;
    in_valid = 0;
    cmd = CMD_ALLOC;
    req_size = 0;
    addr = 0;
    out_stall = 0;
    base_reg = 0;
    limit_reg = HEAP_LIMIT_RESET;
    blk_count = 0;
    end_offset = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    directed = '{
      '{CMD_ALLOC, 32'd0,          32'd0,          1, 32'd16, ST_OK},
      '{CMD_FREE,  32'd0,          32'd0,          1, 32'd0,  ST_NULL},
      '{CMD_FREE,  32'd0,          32'd12345,      1, 32'd0,  ST_UNKNOWN},
      '{CMD_FREE,  32'hFFFFFFFF,   32'd16,         1, 32'd0,  ST_OK},
      '{CMD_FREE,  32'd0,          32'd16,         1, 32'd0,  ST_DOUBLE},
      '{CMD_ALLOC, 32'hFFFFFFF9,   32'hFFFFFFFF,   1, 32'd0,  ST_NOSPACE},
      '{CMD_ALLOC, 32'hFFFFFFFF,   32'd0,          1, 32'd0,  ST_NOSPACE},
      '{CMD_ALLOC, 32'hFFFFFFF8,   32'd0,          1, 32'd0,  ST_NOSPACE},
      '{CMD_ALLOC, 32'd1,          32'd0,          0, 32'd0,  ST_OK},
      '{CMD_ALLOC, 32'd100,        32'd0,          0, 32'd0,  ST_OK},
      '{CMD_ALLOC, 32'd7,          32'd0,          0, 32'd0,  ST_OK},
      '{CMD_ALLOC, 32'd64,         32'd0,          0, 32'd0,  ST_OK},
      '{CMD_FREE,  32'd0,          32'd48,         0, 32'd0,  ST_OK},
      '{CMD_ALLOC, 32'd40,         32'd0,          0, 32'd0,  ST_OK},
      '{CMD_FREE,  32'd0,          32'd32,         0, 32'd0,  ST_OK},
      '{CMD_FREE,  32'd0,          32'd160,        0, 32'd0,  ST_OK},
      '{CMD_FREE,  32'd0,          32'd184,        0, 32'd0,  ST_OK},
      '{CMD_ALLOC, 32'd8,          32'd0,          0, 32'd0,  ST_OK},
      '{CMD_ALLOC, 32'd1048000,    32'd0,          0, 32'd0,  ST_OK},
      '{CMD_FREE,  32'd0,          32'hFFFFFFFF,   0, 32'd0,  ST_OK},
      '{CMD_ALLOC, 32'h7FFFFFFF,   32'd0,          0, 32'd0,  ST_OK}
    };
    foreach (directed[i]) send(directed[i]);
    drain();

    write_reg(CFG_HEAP_BASE, 32'd0);
    write_reg(CFG_HEAP_LIMIT, HEAP_LIMIT_RESET);
    random_requests(150, 3);
    drain();

    write_reg(CFG_HEAP_BASE, 32'hFFFFF000);
    write_reg(CFG_HEAP_LIMIT, 32'hFFFFFFFF);
    tx_quiet = 1;
    rx_quiet = 1;
    random_requests(60, 5);
    tx_quiet = 0;
    rx_quiet = 0;
    rx_hold = 3000;
    random_requests(60, 5);
    drain();

    write_reg(CFG_HEAP_BASE, 32'h00001000);
    write_reg(CFG_HEAP_LIMIT, 32'h00003000);
    random_requests(150, 2);
    drain();

    write_reg(CFG_HEAP_BASE, 32'hFFFFFFFF);
    write_reg(CFG_HEAP_LIMIT, 32'd0);
    random_requests(60, 10);
    drain();

    write_reg(CFG_HEAP_BASE, 32'h00000100);
    write_reg(CFG_HEAP_LIMIT, 32'h00080000);
    random_requests(150, 3);
    @(negedge clk);
    in_valid <= 0;
    drain();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
